/* src/rgbtc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbtc_pkg
// Types, constants and helpers for the RGBA to terminal colour code block.
// ---------------------------------------------------------------------------
package rgbtc_pkg;

  // Palette depth in use (2 .. 16); the entry field is fixed at 4 bits
  localparam int PALETTE_ENTRIES = 16;
  localparam int ENTRY_W         = 4;
  localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(PALETTE_ENTRIES - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_BAND   = 2'd1;

  // Output modes
  localparam logic [1:0] MODE_CUBE_GRAY = 2'd0;
  localparam logic [1:0] MODE_PAL_CODE  = 2'd1;

  // Reset values
  localparam logic [1:0] OUTPUT_MODE_RST = MODE_CUBE_GRAY;
  localparam logic [7:0] GRAY_BAND_RST   = 8'h16;

  // Cube and gray ramp offsets
  localparam logic [7:0] CUBE_BASE = 8'h10;
  localparam logic [7:0] GRAY_BASE = 8'he8;

  // Input actions
  localparam logic ACT_CONVERT = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  typedef struct packed {
    logic               action;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [ENTRY_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [7:0] colour_code;
    logic       went_gray;
  } out_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCALE  = 6'b000010,
    ST_LUM    = 6'b000100,
    ST_CLASS  = 6'b001000,
    ST_SEARCH = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
    abs_diff = (x > y) ? (x - y) : (y - x);
  endfunction

  // Fixed 256-colour code of each palette index
  function automatic logic [7:0] code_of_index(input logic [ENTRY_W-1:0] idx);
    case (idx)
      4'd0:    code_of_index = 8'h10;
      4'd1:    code_of_index = 8'h12;
      4'd2:    code_of_index = 8'h1c;
      4'd3:    code_of_index = 8'h1e;
      4'd4:    code_of_index = 8'h58;
      4'd5:    code_of_index = 8'h5a;
      4'd6:    code_of_index = 8'h64;
      4'd7:    code_of_index = 8'hfa;
      4'd8:    code_of_index = 8'hf4;
      4'd9:    code_of_index = 8'h15;
      4'd10:   code_of_index = 8'h2e;
      4'd11:   code_of_index = 8'h33;
      4'd12:   code_of_index = 8'hc4;
      4'd13:   code_of_index = 8'hc9;
      4'd14:   code_of_index = 8'he2;
      default: code_of_index = 8'he7;
    endcase
  endfunction

endpackage

/* src/rgba_to_terminal_colour_code.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgba_to_terminal_colour_code
// Converts an RGBA pixel to a terminal colour number (cube/gray or nearest
// of a loadable 16-entry palette); load transactions write the palette.
// ---------------------------------------------------------------------------
// Cube/gray mode steps through SCALE (one channel at a time), LUM, CLASS and DONE; palette
// modes through SCALE, SEARCH (every entry) and DONE. Loads write on acceptance, no result.
// One pixel in flight: the next pixel is taken only once the sequencer is back in IDLE,
// later while a result is stalled; the shared alpha multiplier and the
// one-entry-per-cycle distance unit set the pace.
// Reset (rst_n low, synchronous) clears palette, output_mode 0, gray_band 22, out_valid.
// ---------------------------------------------------------------------------
module rgba_to_terminal_colour_code
  import rgbtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel / load channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [1:0] output_mode_r;
  logic [7:0] gray_band_r;

  // Palette: 16 x {r,g,b}, cleared at reset
  logic [23:0] palette_r [16];

  // Sequencer
  state_t             state_r;
  logic [1:0]         chan_r;       // channel being scaled
  logic [ENTRY_W-1:0] entry_r;      // palette entry being compared

  // Pixel working registers
  logic [7:0]         red_r, green_r, blue_r, alpha_r;
  logic [7:0]         lum_r;
  logic [9:0]         best_dist_r;
  logic [ENTRY_W-1:0] best_idx_r;
  out_t               result_r;

  // Output register
  logic out_valid_r;
  out_t out_data_r;

  logic in_acc;
  logic out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // Shared alpha multiplier: c*a/255 via (x + 1 + (x >> 8)) >> 8, exact for
  // every 16-bit product.
  // -------------------------------------------------------------------------
  logic [7:0]  mul_c;
  logic [15:0] mul_p;
  logic [16:0] div_sum;
  logic [7:0]  scaled;

  always_comb begin
    case (chan_r)
      2'd0:    mul_c = red_r;
      2'd1:    mul_c = green_r;
      default: mul_c = blue_r;
    endcase
    mul_p   = mul_c * alpha_r;
    div_sum = {1'b0, mul_p} + 17'd1 + {9'd0, mul_p[15:8]};
    scaled  = div_sum[15:8];
  end

  // -------------------------------------------------------------------------
  // Luminance: (r+g+b)/3 as (sum*683) >> 11, exact up to 765
  // -------------------------------------------------------------------------
  logic [9:0]  lum_sum;
  logic [19:0] lum_prod;
  logic [7:0]  lum_val;

  always_comb begin
    lum_sum  = {2'b00, red_r} + {2'b00, green_r} + {2'b00, blue_r};
    lum_prod = {10'd0, lum_sum} * 20'd683;
    lum_val  = lum_prod[18:11];
  end

  // -------------------------------------------------------------------------
  // Cube / gray classification
  // -------------------------------------------------------------------------
  logic        colourful;
  logic [10:0] r6, g6, b6;
  logic [12:0] lum24;
  logic [7:0]  cube_code, gray_code;

  always_comb begin
    colourful = (abs_diff(red_r, lum_r)   > gray_band_r) ||
                (abs_diff(green_r, lum_r) > gray_band_r) ||
                (abs_diff(blue_r, lum_r)  > gray_band_r);
    r6 = {1'b0, red_r, 2'b00}   + {2'b00, red_r, 1'b0};
    g6 = {1'b0, green_r, 2'b00} + {2'b00, green_r, 1'b0};
    b6 = {1'b0, blue_r, 2'b00}  + {2'b00, blue_r, 1'b0};
    // 16 + 36r' + 6g' + b'
    cube_code = CUBE_BASE
              + {r6[10:8], 5'b00000} + {3'b000, r6[10:8], 2'b00}
              + {3'b000, g6[10:8], 2'b00} + {4'b0000, g6[10:8], 1'b0}
              + {5'b00000, b6[10:8]};
    lum24     = {1'b0, lum_r, 4'h0} + {2'b00, lum_r, 3'h0};
    gray_code = GRAY_BASE + {3'b000, lum24[12:8]};
  end

  // -------------------------------------------------------------------------
  // Shared distance unit: Manhattan distance to one palette entry per cycle
  // -------------------------------------------------------------------------
  logic [23:0] entry_rgb;
  logic [9:0]  entry_dist;
  logic        take_entry;

  always_comb begin
    entry_rgb  = palette_r[entry_r];
    entry_dist = {2'b00, abs_diff(red_r,   entry_rgb[23:16])}
               + {2'b00, abs_diff(green_r, entry_rgb[15:8])}
               + {2'b00, abs_diff(blue_r,  entry_rgb[7:0])};
    // first entry always taken; strict less keeps the lowest index on a tie
    take_entry = (entry_r == '0) || (entry_dist < best_dist_r);
  end

  // -------------------------------------------------------------------------
  // Configuration and palette writes
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_mode_r <= OUTPUT_MODE_RST;
      gray_band_r   <= GRAY_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUTPUT_MODE: output_mode_r <= cfg_data[1:0];
        REG_GRAY_BAND:   gray_band_r   <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        palette_r[i] <= '0;
      end
    end else if (in_acc && in_data.action == ACT_LOAD &&
                 {1'b0, in_data.entry_index} < (ENTRY_W+1)'(PALETTE_ENTRIES)) begin
      palette_r[in_data.entry_index] <= {in_data.red, in_data.green, in_data.blue};
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= '0;
      entry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: filled from DONE, emptied when taken
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_data.action == ACT_CONVERT) begin
            state_r <= ST_SCALE;
            chan_r  <= '0;
          end
        end
        ST_SCALE: begin
          if (chan_r == 2'd2) begin
            state_r <= (output_mode_r == MODE_CUBE_GRAY) ? ST_LUM : ST_SEARCH;
            entry_r <= '0;
          end
          chan_r <= chan_r + 2'd1;
        end
        ST_LUM:   state_r <= ST_CLASS;
        ST_CLASS: state_r <= ST_DONE;
        ST_SEARCH: begin
          if (entry_r == ENTRY_LAST) begin
            state_r <= ST_DONE;
          end
          entry_r <= entry_r + ENTRY_W'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers (no reset)
  always_ff @(posedge clk) begin
    if (in_acc && in_data.action == ACT_CONVERT) begin
      red_r   <= in_data.red;
      green_r <= in_data.green;
      blue_r  <= in_data.blue;
      alpha_r <= in_data.alpha;
    end
    if (state_r == ST_SCALE) begin
      case (chan_r)
        2'd0:    red_r   <= scaled;
        2'd1:    green_r <= scaled;
        default: blue_r  <= scaled;
      endcase
    end
    if (state_r == ST_LUM) begin
      lum_r <= lum_val;
    end
    if (state_r == ST_CLASS) begin
      result_r.colour_code <= colourful ? cube_code : gray_code;
      result_r.went_gray   <= !colourful;
    end
    if (state_r == ST_SEARCH) begin
      if (take_entry) begin
        best_dist_r <= entry_dist;
        best_idx_r  <= entry_r;
      end
      if (entry_r == ENTRY_LAST) begin
        // final pick may be this very entry
        result_r.went_gray <= 1'b0;
        if (output_mode_r == MODE_PAL_CODE) begin
          result_r.colour_code <= code_of_index(take_entry ? entry_r : best_idx_r);
        end else begin
          result_r.colour_code <= {{(8-ENTRY_W){1'b0}},
                                   (take_entry ? entry_r : best_idx_r)};
        end
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= result_r;
    end
  end

endmodule

/* tb/tb_rgba_to_terminal_colour_code.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgba_to_terminal_colour_code
// Self-checking bench for the RGBA to terminal colour code converter.
// A queue-fed driver sends pixel and palette-load transactions. A local
// model of the palette and registers predicts each pixel's colour code,
// and a monitor checks every result against it, field by field. Register
// settings, transaction counts and handshake back-pressure change from one phase
// to the next.
// ---------------------------------------------------------------------------
module tb_rgba_to_terminal_colour_code;
  import rgbtc_pkg::*;

  // Output modes and register slot the package leaves unnamed
  localparam logic [1:0]           MODE_PAL_INDEX = 2'd2;
  localparam logic [1:0]           MODE_SPARE     = 2'd3;  // decodes as raw index
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;  // no register behind it

  // Idle cycles before a register write. Covers the palette-mode latency
  // plus margin, since loads finish without giving a result.
  localparam int HOLD_OFF_CYCLES = 30;

  // Fixed 256-colour code for each palette index, index 0 in the low byte
  localparam logic [127:0] PAL_CODES = {
    8'he7, 8'he2, 8'hc9, 8'hc4, 8'h33, 8'h2e, 8'h15, 8'hf4,
    8'hfa, 8'h64, 8'h5a, 8'h58, 8'h1e, 8'h1c, 8'h12, 8'h10
  };

  // -------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input is known from time zero.
  // -------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rgba_to_terminal_colour_code dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Local model of the block: palette copy and register copies
  // -------------------------------------------------------------------------
  logic [7:0] pal_red   [16];
  logic [7:0] pal_green [16];
  logic [7:0] pal_blue  [16];
  logic [1:0] model_mode = OUTPUT_MODE_RST;
  logic [7:0] model_band = GRAY_BAND_RST;

  in_t  pending_items  [$];  // waiting for the driver
  out_t expected_codes [$];  // predicted results, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int pixels_checked = 0;
  int gray_results   = 0;
  int loads_accepted = 0;
  int reg_writes     = 0;
  int phase_count    = 0;

  function automatic int channel_gap(input int x, input int y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    return (v < 0) ? 8'h00 : (v > 255) ? 8'hff : 8'(v);
  endfunction

  // Colour code the block should give for one pixel under current settings
  function automatic out_t predict_colour(input in_t px);
    int   r, g, b, lum, best, best_dist, d, i;
    out_t res;
    res = '0;
    // alpha premultiply, truncating
    r = int'(px.red)   * int'(px.alpha) / 255;
    g = int'(px.green) * int'(px.alpha) / 255;
    b = int'(px.blue)  * int'(px.alpha) / 255;
    if (model_mode == MODE_CUBE_GRAY) begin
      lum = (r + g + b) / 3;
      if (channel_gap(r, lum) > int'(model_band) || channel_gap(g, lum) > int'(model_band) ||
          channel_gap(b, lum) > int'(model_band)) begin
        res.colour_code = 8'(int'(CUBE_BASE) + 36 * (r * 6 / 256) + 6 * (g * 6 / 256)
                             + b * 6 / 256);
      end else begin
        res.colour_code = 8'(int'(GRAY_BASE) + lum * 24 / 256);
        res.went_gray   = 1'b1;
      end
    end else begin
      // Manhattan search, strict less-than so the lowest index wins a tie
      best      = 0;
      best_dist = 32'h7fffffff;
      for (i = 0; i < PALETTE_ENTRIES; i++) begin
        d = channel_gap(r, int'(pal_red[i])) + channel_gap(g, int'(pal_green[i]))
          + channel_gap(b, int'(pal_blue[i]));
        if (d < best_dist) begin
          best_dist = d;
          best      = i;
        end
      end
      if (model_mode == MODE_PAL_CODE) begin
        res.colour_code = PAL_CODES[best*8 +: 8];
      end else begin
        res.colour_code = 8'(best);  // raw index, also for the spare mode
      end
    end
    return res;
  endfunction

  // Update the model with one accepted transaction
  task automatic track_transaction(input in_t item);
    if (item.action == ACT_LOAD) begin
      if (int'(item.entry_index) < PALETTE_ENTRIES) begin
        pal_red[item.entry_index]   = item.red;
        pal_green[item.entry_index] = item.green;
        pal_blue[item.entry_index]  = item.blue;
      end
      loads_accepted++;
    end else begin
      expected_codes.push_back(predict_colour(item));
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: presents queued transactions, random idle gaps between them.
  // A stalled transaction is held unchanged until it is taken.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_transaction(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each accepted result, stalls the result channel at random
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: code %0d gray %0b",
                                    out_data.colour_code, out_data.went_gray));
        end else begin
          want = expected_codes.pop_front();
          pixels_checked++;
          if (want.went_gray) gray_results++;
          if (out_data.colour_code !== want.colour_code) begin
            report_mismatch($sformatf("colour_code %0d, expected %0d (mode %0d)",
                                      out_data.colour_code, want.colour_code, model_mode));
          end
          if (out_data.went_gray !== want.went_gray) begin
            report_mismatch($sformatf("went_gray %0b, expected %0b (code %0d)",
                                      out_data.went_gray, want.went_gray, want.colour_code));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  // Sampled on the falling edge so queue and valid have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_codes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Drain, then let any trailing load transaction finish before touching registers
  task automatic settle();
    wait_drained();
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OUTPUT_MODE) begin
      model_mode = value[1:0];
    end else if (idx == REG_GRAY_BAND) begin
      model_band = value;
    end
    reg_writes++;
  endtask

  // entry_index is don't-care on a pixel; randomise it anyway
  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
    in_t item;
    item             = '0;
    item.action      = ACT_CONVERT;
    item.red         = r;
    item.green       = g;
    item.blue        = b;
    item.alpha       = a;
    item.entry_index = ENTRY_W'($urandom);
    pending_items.push_back(item);
  endtask

  // alpha is ignored on a load; randomise it anyway
  task automatic queue_load(input logic [ENTRY_W-1:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    in_t item;
    item             = '0;
    item.action      = ACT_LOAD;
    item.red         = r;
    item.green       = g;
    item.blue        = b;
    item.alpha       = 8'($urandom);
    item.entry_index = idx;
    pending_items.push_back(item);
  endtask

  // Mixed traffic: loads (some duplicating an entry to force ties), near-gray
  // pixels, pixels close to a palette entry, saturated and fully random ones
  task automatic queue_random(input int n);
    int         k, kind, sel, base, e;
    logic [7:0] a;
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      if (kind < 18) begin
        if ($urandom_range(3) == 0) begin
          e = $urandom_range(15);
          queue_load(ENTRY_W'($urandom), pal_red[e], pal_green[e], pal_blue[e]);
        end else begin
          queue_load(ENTRY_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end else begin
        sel = $urandom_range(9);
        a   = (sel < 5) ? 8'hff : (sel == 5) ? 8'h00 : 8'($urandom);
        if (kind < 45) begin
          base = $urandom_range(255);
          queue_pixel(clamp_byte(base + int'($urandom_range(60)) - 30),
                      clamp_byte(base + int'($urandom_range(60)) - 30),
                      clamp_byte(base + int'($urandom_range(60)) - 30), a);
        end else if (kind < 65) begin
          e = $urandom_range(PALETTE_ENTRIES - 1);
          queue_pixel(clamp_byte(int'(pal_red[e])   + int'($urandom_range(6)) - 3),
                      clamp_byte(int'(pal_green[e]) + int'($urandom_range(6)) - 3),
                      clamp_byte(int'(pal_blue[e])  + int'($urandom_range(6)) - 3), a);
        end else if (kind < 75) begin
          queue_pixel($urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
                      $urandom_range(1) ? 8'hff : 8'h00, a);
        end else begin
          queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), a);
        end
      end
    end
  endtask

  // One phase: new settings, new handshake pressure, and a mid-phase pause
  // in which the sender holds off until every result is back
  task automatic run_phase(input logic [1:0] mode, input logic [7:0] band,
                           input int idle_pct, input int stall_pct, input int n);
    settle();
    write_reg(REG_OUTPUT_MODE, {6'd0, mode});
    write_reg(REG_GRAY_BAND, band);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_count++;
    queue_random(n / 2);
    wait_drained();
    queue_random(n - n / 2);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_sequence
    int i;
    for (i = 0; i < 16; i++) begin
      pal_red[i]   = 8'h00;
      pal_green[i] = 8'h00;
      pal_blue[i]  = 8'h00;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset register values, cube/gray extremes
    queue_pixel(8'h00, 8'h00, 8'h00, 8'hff);  // black, bottom of gray ramp
    queue_pixel(8'hff, 8'hff, 8'hff, 8'hff);  // white, top of gray ramp
    queue_pixel(8'hff, 8'h00, 8'h00, 8'hff);  // pure red into the cube
    queue_pixel(8'hff, 8'hff, 8'hff, 8'h00);  // fully transparent
    queue_pixel(8'h00, 8'hff, 8'hff, 8'h80);  // half alpha cyan
    queue_pixel(8'hc8, 8'hb4, 8'hbe, 8'hff);  // just inside the default band

    // Palette modes on the cleared palette: every entry ties, index 0 wins
    settle();
    write_reg(REG_SPARE, 8'hff);  // unmapped slot, must change nothing
    write_reg(REG_OUTPUT_MODE, {6'd0, MODE_PAL_CODE});
    queue_pixel(8'h7b, 8'h2d, 8'h43, 8'hff);
    queue_load(ENTRY_LAST, 8'hff, 8'hff, 8'hff);
    queue_load(4'd3, 8'hff, 8'h00, 8'h00);
    queue_load(4'd5, 8'hff, 8'h00, 8'h00);   // duplicate of entry 3: tie
    queue_load(4'd0, 8'h00, 8'h00, 8'hff);
    queue_pixel(8'hfa, 8'h05, 8'h05, 8'hff);
    queue_pixel(8'hff, 8'hff, 8'hff, 8'hff);

    settle();
    write_reg(REG_OUTPUT_MODE, {6'd0, MODE_PAL_INDEX});
    queue_pixel(8'hfa, 8'h05, 8'h05, 8'hff);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'hff);

    // Spare mode code falls back to the raw index
    settle();
    write_reg(REG_OUTPUT_MODE, {6'd0, MODE_SPARE});
    queue_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    queue_pixel(8'h10, 8'h20, 8'h30, 8'h40);
    phase_count++;

    // Random phases: band extremes, all modes, each pressure pattern
    run_phase(MODE_CUBE_GRAY, 8'd0,              0,  0,  80);
    run_phase(MODE_CUBE_GRAY, 8'd255,            52, 0,  80);
    run_phase(MODE_PAL_CODE,  8'($urandom),      0,  52, 80);
    run_phase(MODE_PAL_INDEX, GRAY_BAND_RST,     14, 14, 80);
    run_phase(MODE_SPARE,     8'($urandom),      52, 0,  60);
    run_phase(MODE_CUBE_GRAY, 8'($urandom_range(40)), 0, 52, 100);
    run_phase(MODE_PAL_CODE,  GRAY_BAND_RST,     14, 14, 80);
    run_phase(MODE_CUBE_GRAY, GRAY_BAND_RST,     0,  0,  80);

    // Drain and allow trailing activity to show up
    settle();

    $display("Covered %0d phases, %0d register writes, %0d palette loads.",
             phase_count, reg_writes, loads_accepted);
    $display("Checked %0d pixel results, %0d of them on the gray ramp; %0d mismatches.",
             pixels_checked, gray_results, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: 10 ms is far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("Timeout: results still outstanding (%0d expected)", expected_codes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
src/rgbtc_pkg.sv
src/rgba_to_terminal_colour_code.sv
tb/tb_rgba_to_terminal_colour_code.sv
